// ===== rtl/core/jlts_pkg.sv =====
// Shared types and constants of the token scanner.
package jlts_pkg;

  // Position counter and token length widths
  localparam int POS_W = 32;
  localparam int LEN_W = 16;

  // Result queue depth
  localparam int FIFO_DEPTH = 4;

  // Token types
  localparam logic [3:0] T_OBJ_START  = 4'd0;
  localparam logic [3:0] T_OBJ_END    = 4'd1;
  localparam logic [3:0] T_LIST_START = 4'd2;
  localparam logic [3:0] T_LIST_END   = 4'd3;
  localparam logic [3:0] T_COMMA      = 4'd4;
  localparam logic [3:0] T_COLON      = 4'd5;
  localparam logic [3:0] T_INT        = 4'd6;
  localparam logic [3:0] T_FLOAT      = 4'd7;
  localparam logic [3:0] T_STRING     = 4'd8;
  localparam logic [3:0] T_BOOL       = 4'd9;
  localparam logic [3:0] T_IDENT      = 4'd10;
  localparam logic [3:0] T_LINE_CMT   = 4'd11;
  localparam logic [3:0] T_BLOCK_CMT  = 4'd12;
  localparam logic [3:0] T_SPACE      = 4'd13;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_DOTS    = 2'd2;

  // Configuration register indexes
  localparam logic CFG_KEEP_COMMENTS = 1'b0;
  localparam logic CFG_KEEP_SPACE    = 1'b1;

  // Scanner modes
  typedef enum logic [2:0] {
    M_IDLE,
    M_WS,
    M_NUM,
    M_STR,
    M_IDENT,
    M_SLASH,
    M_LINE,
    M_BLOCK
  } jlts_mode_e;

  // One token record
  typedef struct packed {
    logic [3:0]       token_type;
    logic [1:0]       error_code;
    logic [POS_W-1:0] start_offset;
    logic [POS_W-1:0] start_line;
    logic [POS_W-1:0] start_column;
    logic [LEN_W-1:0] token_length;
    logic             last_of_run;
  } jlts_rec_t;

  // Records produced by one request, in order
  typedef struct packed {
    logic [1:0] count;
    jlts_rec_t  rec0;
    jlts_rec_t  rec1;
  } jlts_push_t;

endpackage

// ===== rtl/core/json_like_token_scanner_top.sv =====
// Top level of the JSON-like token scanner.
//
// Input channel (in_valid_i/in_ready_o): one request per byte. kind_i = 0
// carries data_byte_i; kind_i = 1 marks end of input, which closes any pending
// token and returns offset, line, column and the halt flag to zero.
// Output channel (out_valid_o/out_ready_i): one token record per transfer;
// a request yields zero, one or two records, and last_of_run_o marks the
// final record of a request.
// Configuration: cfg_we_i writes register cfg_idx_i (0 keep comments,
// 1 keep whitespace) from cfg_data_i in the same cycle.
// A record is written into the result queue and is visible once the records ahead of it have gone.
// Throughput: one byte per cycle while in_ready_o is high; the scan step is combinational logic.
// Records go into a four-entry queue; in_ready_o drops while fewer than two
// entries are free, so a stalled receiver backs up into the input channel
// without losing records.
// Reset: scanner idle, counters zero, both options off, queue empty.
module json_like_token_scanner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_type_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] start_offset_o,
  output logic [31:0] start_line_o,
  output logic [31:0] start_column_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  jlts_pkg::jlts_push_t push;
  jlts_pkg::jlts_rec_t  rec;
  logic                 space;
  logic                 acc;

  assign in_ready_o = space;
  assign acc        = in_valid_i && space;

  jlts_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .push_o      (push)
  );

  jlts_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rec_o   (rec)
  );

  // Record fields to ports
  assign token_type_o   = rec.token_type;
  assign error_code_o   = rec.error_code;
  assign start_offset_o = rec.start_offset;
  assign start_line_o   = rec.start_line;
  assign start_column_o = rec.start_column;
  assign token_length_o = rec.token_length;
  assign last_of_run_o  = rec.last_of_run;

endmodule

// ===== rtl/core/jlts_scan.sv =====
// Byte classifier and scanner state: turns one request into up to two records.
module jlts_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               acc_i,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  output jlts_pkg::jlts_push_t push_o
);

  localparam logic [7:0] C_LBRACE = 8'h7B;
  localparam logic [7:0] C_RBRACE = 8'h7D;
  localparam logic [7:0] C_LBRACK = 8'h5B;
  localparam logic [7:0] C_RBRACK = 8'h5D;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_COLON  = 8'h3A;
  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_SLASH  = 8'h2F;
  localparam logic [7:0] C_STAR   = 8'h2A;
  localparam logic [7:0] C_BSLASH = 8'h5C;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_LF     = 8'h0A;

  // Keyword tracker codes: 1..4 walk "true", 5..9 walk "false"
  localparam logic [3:0] KW_NONE  = 4'd0;
  localparam logic [3:0] KW_T     = 4'd1;
  localparam logic [3:0] KW_TRUE  = 4'd4;
  localparam logic [3:0] KW_F     = 4'd5;
  localparam logic [3:0] KW_FALSE = 4'd9;
  localparam logic [3:0] KW_DEAD  = 4'd15;

  localparam logic [jlts_pkg::LEN_W-1:0] LEN_MAX = {jlts_pkg::LEN_W{1'b1}};
  localparam logic [jlts_pkg::LEN_W-1:0] LEN_ONE = jlts_pkg::LEN_W'(1);
  localparam logic [jlts_pkg::POS_W-1:0] POS_ONE = jlts_pkg::POS_W'(1);

  // Next keyword tracker code after one more alphanumeric byte
  function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
    logic [3:0] r;
    begin
      r = KW_DEAD;
      case (k)
        4'd1: if (c == 8'h72) r = 4'd2;   // r
        4'd2: if (c == 8'h75) r = 4'd3;   // u
        4'd3: if (c == 8'h65) r = 4'd4;   // e
        4'd5: if (c == 8'h61) r = 4'd6;   // a
        4'd6: if (c == 8'h6C) r = 4'd7;   // l
        4'd7: if (c == 8'h73) r = 4'd8;   // s
        4'd8: if (c == 8'h65) r = 4'd9;   // e
        default: r = KW_DEAD;
      endcase
      return r;
    end
  endfunction

  // Configuration
  logic keep_cmt_q, keep_ws_q;

  // Scanner state
  jlts_pkg::jlts_mode_e mode_q, mode_d;
  logic [3:0]                 ptype_q, ptype_d;
  logic                       dot_q, dot_d;
  logic                       esc_q, esc_d;
  logic                       star_q, star_d;
  logic [3:0]                 kw_q, kw_d;
  logic [jlts_pkg::POS_W-1:0] st_off_q, st_off_d;
  logic [jlts_pkg::POS_W-1:0] st_line_q, st_line_d;
  logic [jlts_pkg::POS_W-1:0] st_col_q, st_col_d;
  logic [jlts_pkg::LEN_W-1:0] tb_q, tb_d;
  logic [jlts_pkg::POS_W-1:0] off_q, off_d;
  logic [jlts_pkg::POS_W-1:0] line_q, line_d;
  logic [jlts_pkg::POS_W-1:0] col_q, col_d;
  logic                       halted_q, halted_d;

  // Byte classes
  logic       is_ws, is_dig, is_alp, is_punct;
  logic [3:0] punct_type;
  logic       data_go, fresh, adv;
  logic [jlts_pkg::LEN_W-1:0] tb_inc;

  assign is_ws  = (data_byte_i == C_SPACE) || (data_byte_i == C_TAB) ||
                  (data_byte_i == C_CR) || (data_byte_i == C_LF);
  assign is_dig = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign is_alp = ((data_byte_i >= 8'h61) && (data_byte_i <= 8'h7A)) ||
                  ((data_byte_i >= 8'h41) && (data_byte_i <= 8'h5A));
  assign tb_inc = (tb_q == LEN_MAX) ? tb_q : tb_q + LEN_ONE;

  // Punctuation lookup
  always_comb begin
    is_punct   = 1'b1;
    punct_type = jlts_pkg::T_OBJ_START;
    case (data_byte_i)
      C_LBRACE: punct_type = jlts_pkg::T_OBJ_START;
      C_RBRACE: punct_type = jlts_pkg::T_OBJ_END;
      C_LBRACK: punct_type = jlts_pkg::T_LIST_START;
      C_RBRACK: punct_type = jlts_pkg::T_LIST_END;
      C_COMMA:  punct_type = jlts_pkg::T_COMMA;
      C_COLON:  punct_type = jlts_pkg::T_COLON;
      default:  is_punct   = 1'b0;
    endcase
  end

  // A data byte that ends the pending token (or finds none) starts a new one
  assign data_go = acc_i && !kind_i && !halted_q;
  always_comb begin
    case (mode_q)
      jlts_pkg::M_IDLE:  fresh = data_go;
      jlts_pkg::M_WS:    fresh = data_go && !is_ws;
      jlts_pkg::M_NUM:   fresh = data_go && !is_dig && (data_byte_i != C_DOT);
      jlts_pkg::M_IDENT: fresh = data_go && !is_alp && !is_dig;
      default:           fresh = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    mode_d    = mode_q;
    ptype_d   = ptype_q;
    dot_d     = dot_q;
    esc_d     = esc_q;
    star_d    = star_q;
    kw_d      = kw_q;
    st_off_d  = st_off_q;
    st_line_d = st_line_q;
    st_col_d  = st_col_q;
    tb_d      = tb_q;
    halted_d  = halted_q;
    adv       = 1'b0;

    if (acc_i && kind_i) begin
      // end of input: back to the reset state
      mode_d    = jlts_pkg::M_IDLE;
      ptype_d   = jlts_pkg::T_OBJ_START;
      dot_d     = 1'b0;
      esc_d     = 1'b0;
      star_d    = 1'b0;
      kw_d      = KW_NONE;
      st_off_d  = '0;
      st_line_d = '0;
      st_col_d  = '0;
      tb_d      = '0;
      halted_d  = 1'b0;
    end else if (data_go && !fresh) begin
      // continue the pending token
      case (mode_q)
        jlts_pkg::M_WS: begin
          adv  = 1'b1;
          tb_d = tb_inc;
        end
        jlts_pkg::M_NUM: begin
          if (is_dig) begin
            adv  = 1'b1;
            tb_d = tb_inc;
          end else if (dot_q) begin
            halted_d = 1'b1;
            mode_d   = jlts_pkg::M_IDLE;
          end else begin
            dot_d   = 1'b1;
            ptype_d = jlts_pkg::T_FLOAT;
            adv     = 1'b1;
            tb_d    = tb_inc;
          end
        end
        jlts_pkg::M_STR: begin
          adv  = 1'b1;
          tb_d = tb_inc;
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (data_byte_i == C_BSLASH) begin
            esc_d = 1'b1;
          end else if (data_byte_i == C_QUOTE) begin
            mode_d = jlts_pkg::M_IDLE;
          end
        end
        jlts_pkg::M_IDENT: begin
          kw_d = kw_next(kw_q, data_byte_i);
          adv  = 1'b1;
          tb_d = tb_inc;
        end
        jlts_pkg::M_SLASH: begin
          adv  = 1'b1;
          tb_d = tb_inc;
          if (data_byte_i == C_SLASH) begin
            mode_d  = jlts_pkg::M_LINE;
            ptype_d = jlts_pkg::T_LINE_CMT;
          end else if (data_byte_i == C_STAR) begin
            mode_d  = jlts_pkg::M_BLOCK;
            ptype_d = jlts_pkg::T_BLOCK_CMT;
            star_d  = 1'b0;
          end else begin
            halted_d = 1'b1;
            mode_d   = jlts_pkg::M_IDLE;
          end
        end
        jlts_pkg::M_LINE: begin
          adv  = 1'b1;
          tb_d = tb_inc;
          if ((data_byte_i == C_LF) || (data_byte_i == C_CR)) begin
            mode_d = jlts_pkg::M_IDLE;
          end
        end
        jlts_pkg::M_BLOCK: begin
          adv  = 1'b1;
          tb_d = tb_inc;
          if (star_q && (data_byte_i == C_SLASH)) begin
            mode_d = jlts_pkg::M_IDLE;
          end else begin
            star_d = (data_byte_i == C_STAR);
          end
        end
        default: begin
          mode_d = jlts_pkg::M_IDLE;
        end
      endcase
    end else if (fresh) begin
      // open a new token at the current position
      st_off_d  = off_q;
      st_line_d = line_q;
      st_col_d  = col_q;
      tb_d      = LEN_ONE;
      dot_d     = 1'b0;
      esc_d     = 1'b0;
      star_d    = 1'b0;
      kw_d      = KW_NONE;
      adv       = 1'b1;
      if (is_ws) begin
        mode_d  = jlts_pkg::M_WS;
        ptype_d = jlts_pkg::T_SPACE;
      end else if (is_punct) begin
        mode_d  = jlts_pkg::M_IDLE;
        ptype_d = punct_type;
      end else if (is_dig || (data_byte_i == C_DOT) || (data_byte_i == C_MINUS)) begin
        mode_d  = jlts_pkg::M_NUM;
        ptype_d = (data_byte_i == C_DOT) ? jlts_pkg::T_FLOAT : jlts_pkg::T_INT;
        dot_d   = (data_byte_i == C_DOT);
      end else if (data_byte_i == C_QUOTE) begin
        mode_d  = jlts_pkg::M_STR;
        ptype_d = jlts_pkg::T_STRING;
      end else if (is_alp) begin
        mode_d  = jlts_pkg::M_IDENT;
        ptype_d = jlts_pkg::T_IDENT;
        kw_d    = (data_byte_i == 8'h74) ? KW_T : (data_byte_i == 8'h66) ? KW_F : KW_DEAD;
      end else if (data_byte_i == C_SLASH) begin
        mode_d  = jlts_pkg::M_SLASH;
        ptype_d = jlts_pkg::T_OBJ_START;
      end else begin
        // invalid byte: error record, halt, counters hold
        mode_d   = jlts_pkg::M_IDLE;
        ptype_d  = jlts_pkg::T_OBJ_START;
        halted_d = 1'b1;
        adv      = 1'b0;
      end
    end
  end

  // Running position
  always_comb begin
    off_d  = off_q;
    line_d = line_q;
    col_d  = col_q;
    if (acc_i && kind_i) begin
      off_d  = '0;
      line_d = '0;
      col_d  = '0;
    end else if (adv) begin
      off_d = off_q + POS_ONE;
      if (data_byte_i == C_LF) begin
        line_d = line_q + POS_ONE;
        col_d  = '0;
      end else begin
        col_d = col_q + POS_ONE;
      end
    end
  end

  // Records
  logic       a_v, b_v, close_keep;
  logic [3:0] close_type, a_type, b_type;
  logic [1:0] a_err, b_err;
  logic [jlts_pkg::LEN_W-1:0] a_len;
  jlts_pkg::jlts_rec_t rec_a, rec_b;

  always_comb begin
    if (mode_q == jlts_pkg::M_IDENT) begin
      close_type = ((kw_q == KW_TRUE) || (kw_q == KW_FALSE)) ? jlts_pkg::T_BOOL
                                                             : jlts_pkg::T_IDENT;
    end else begin
      close_type = ptype_q;
    end
    close_keep = 1'b1;
    if (((close_type == jlts_pkg::T_LINE_CMT) || (close_type == jlts_pkg::T_BLOCK_CMT)) &&
        !keep_cmt_q) begin
      close_keep = 1'b0;
    end
    if ((close_type == jlts_pkg::T_SPACE) && !keep_ws_q) begin
      close_keep = 1'b0;
    end
  end

  // First record: the pending token closing, or an error on it
  always_comb begin
    a_v    = 1'b0;
    a_type = close_type;
    a_err  = jlts_pkg::ERR_NONE;
    a_len  = tb_q;
    if (acc_i && kind_i && !halted_q) begin
      if (mode_q == jlts_pkg::M_SLASH) begin
        a_v    = 1'b1;
        a_type = jlts_pkg::T_OBJ_START;
        a_err  = jlts_pkg::ERR_INVALID;
      end else if (mode_q != jlts_pkg::M_IDLE) begin
        a_v = close_keep;
      end
    end else if (fresh) begin
      a_v = (mode_q != jlts_pkg::M_IDLE) && close_keep;
    end else if (data_go) begin
      case (mode_q)
        jlts_pkg::M_NUM: begin
          if (!is_dig && dot_q) begin
            a_v    = 1'b1;
            a_type = jlts_pkg::T_FLOAT;
            a_err  = jlts_pkg::ERR_DOTS;
          end
        end
        jlts_pkg::M_STR: begin
          a_v   = !esc_q && (data_byte_i == C_QUOTE) && close_keep;
          a_len = tb_inc;
        end
        jlts_pkg::M_SLASH: begin
          a_v    = (data_byte_i != C_SLASH) && (data_byte_i != C_STAR);
          a_type = jlts_pkg::T_OBJ_START;
          a_err  = jlts_pkg::ERR_INVALID;
          a_len  = tb_inc;
        end
        jlts_pkg::M_LINE: begin
          a_v   = ((data_byte_i == C_LF) || (data_byte_i == C_CR)) && close_keep;
          a_len = tb_inc;
        end
        jlts_pkg::M_BLOCK: begin
          a_v   = star_q && (data_byte_i == C_SLASH) && close_keep;
          a_len = tb_inc;
        end
        default: a_v = 1'b0;
      endcase
    end
  end

  // Second record: punctuation or an invalid byte at the current position
  always_comb begin
    b_v    = 1'b0;
    b_type = jlts_pkg::T_OBJ_START;
    b_err  = jlts_pkg::ERR_NONE;
    if (fresh && !is_ws) begin
      if (is_punct) begin
        b_v    = 1'b1;
        b_type = punct_type;
      end else if (!is_dig && !is_alp && (data_byte_i != C_DOT) &&
                   (data_byte_i != C_MINUS) && (data_byte_i != C_QUOTE) &&
                   (data_byte_i != C_SLASH)) begin
        b_v   = 1'b1;
        b_err = jlts_pkg::ERR_INVALID;
      end
    end
  end

  always_comb begin
    rec_a.token_type   = a_type;
    rec_a.error_code   = a_err;
    rec_a.start_offset = st_off_q;
    rec_a.start_line   = st_line_q;
    rec_a.start_column = st_col_q;
    rec_a.token_length = a_len;
    rec_a.last_of_run  = !b_v;

    rec_b.token_type   = b_type;
    rec_b.error_code   = b_err;
    rec_b.start_offset = off_q;
    rec_b.start_line   = line_q;
    rec_b.start_column = col_q;
    rec_b.token_length = LEN_ONE;
    rec_b.last_of_run  = 1'b1;

    push_o.count = {1'b0, a_v} + {1'b0, b_v};
    push_o.rec0  = a_v ? rec_a : rec_b;
    push_o.rec1  = rec_b;
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_cmt_q <= 1'b0;
      keep_ws_q  <= 1'b0;
      mode_q     <= jlts_pkg::M_IDLE;
      ptype_q    <= jlts_pkg::T_OBJ_START;
      dot_q      <= 1'b0;
      esc_q      <= 1'b0;
      star_q     <= 1'b0;
      kw_q       <= KW_NONE;
      st_off_q   <= '0;
      st_line_q  <= '0;
      st_col_q   <= '0;
      tb_q       <= '0;
      off_q      <= '0;
      line_q     <= '0;
      col_q      <= '0;
      halted_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == jlts_pkg::CFG_KEEP_COMMENTS)) keep_cmt_q <= cfg_data_i;
      if (cfg_we_i && (cfg_idx_i == jlts_pkg::CFG_KEEP_SPACE))    keep_ws_q  <= cfg_data_i;
      mode_q    <= mode_d;
      ptype_q   <= ptype_d;
      dot_q     <= dot_d;
      esc_q     <= esc_d;
      star_q    <= star_d;
      kw_q      <= kw_d;
      st_off_q  <= st_off_d;
      st_line_q <= st_line_d;
      st_col_q  <= st_col_d;
      tb_q      <= tb_d;
      off_q     <= off_d;
      line_q    <= line_d;
      col_q     <= col_d;
      halted_q  <= halted_d;
    end
  end

  // A halted scanner ignores data bytes entirely
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !kind_i && halted_q) |-> (push_o.count == 2'd0))
    else $error("halted scanner produced a record");

  a_halt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !kind_i && halted_q) |=> $stable(off_q) && halted_q)
    else $error("halted scanner moved its position");

  // End of input re-arms the scanner at offset zero
  a_eoi_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && kind_i) |=> (off_q == '0) && !halted_q && (mode_q == jlts_pkg::M_IDLE))
    else $error("end of input did not re-arm the scanner");

endmodule

// ===== rtl/core/jlts_fifo.sv =====
// Result queue: takes up to two records per cycle, hands out one.
module jlts_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jlts_pkg::jlts_push_t push_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output jlts_pkg::jlts_rec_t  out_rec_o
);

  localparam int PTR_W = $clog2(jlts_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(jlts_pkg::FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(jlts_pkg::FIFO_DEPTH);
  localparam logic [CNT_W-1:0] ROOM_C  = CNT_W'(jlts_pkg::FIFO_DEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

  jlts_pkg::jlts_rec_t mem_q [jlts_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_rec_o   = mem_q[rd_q];
  assign space_o     = (cnt_q <= ROOM_C);
  assign pop         = out_valid_o && out_ready_i;

  // Pointers and fill level
  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.count);
    rd_d  = pop ? rd_q + PTR_ONE : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.rec0;
    if (push_i.count == 2'd2) mem_q[wr_q + PTR_ONE] <= push_i.rec1;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> ((cnt_q + CNT_W'(push_i.count)) <= DEPTH_C))
    else $error("result queue overflow");

  a_level_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("queue level changed without push or pop");

  // Pointer distance always matches the fill level
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wr_q - rd_q) == PTR_W'(cnt_q)))
    else $error("queue pointers disagree with fill level");

endmodule
